@@ rtl/dwd_pkg.sv @@
package dwd_pkg;

	localparam int MAX_HITS_DEF = 1000;
	localparam int FIFO_DEPTH   = 4;

	localparam logic [1:0] KIND_ADC_HIT = 2'd0;
	localparam logic [1:0] KIND_TDC_HIT = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_ADC_HEADER    = 4'd1;
	localparam logic [3:0] ERR_ADC_NON_EVENT = 4'd2;
	localparam logic [3:0] ERR_ADC_UNKNOWN   = 4'd3;
	localparam logic [3:0] ERR_LAYER_ORDER   = 4'd4;
	localparam logic [3:0] ERR_OUTSIDE_LAYER = 4'd5;
	localparam logic [3:0] ERR_HIT_LIMIT     = 4'd6;
	localparam logic [3:0] ERR_TDC_ERROR     = 4'd7;
	localparam logic [3:0] ERR_TDC_UNKNOWN   = 4'd8;

	typedef struct packed {
		logic [1:0]  kind;
		logic        module_bit;
		logic [6:0]  channel;
		logic [18:0] value;
		logic        trailing_edge;
		logic [3:0]  error_code;
		logic [15:0] word_count;
		logic        last;
	} rec_t;

	typedef struct packed {
		logic [1:0] n;
		rec_t       rec0;
		rec_t       rec1;
	} push_t;

	function automatic rec_t err_rec(input logic [3:0] code);
		rec_t r;
		r            = '0;
		r.kind       = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

endpackage

@@ rtl/daq_event_word_decoder.sv @@
// Event word decoder for a data-acquisition readout stream.
// Slave channel: one raw 16-bit event word per transfer on s_tdata[15:0];
// s_tlast marks the final word of the event.
// Master channel: one record per transfer. m_tuser carries the record kind
// (ADC hit, TDC hit, error, event done); m_tlast is set on the last record
// that a given input word causes.
// A word is registered in the input stage at its transfer and decoded from
// there; its records are written into the queue and shown on the master side
// from the queue's registers. The decode pass handles one word per cycle
// while the queue has room, so words stream at one per cycle while each causes
// at most one record and the master side takes them; a word that causes two
// records (a hit or error plus the done record) goes out as two master transfers.
// A four-entry record queue separates the sides: input is taken while it has
// room for two records, so a stall on the master side backs up into s_tready
// once the queue holds three or more records. No record is dropped.
// Reset clears the parse state, the queue and the input stage; the first
// word after reset is taken as a segment size word.
module daq_event_word_decoder #(
	parameter int MAX_HITS = dwd_pkg::MAX_HITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] data_word
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [0] module_bit, [7:1] channel, [26:8] value,
	                               // [27] trailing_edge, [31:28] error_code,
	                               // [47:32] word_count
	output logic [1:0]  m_tuser,   // [1:0] record_kind
	output logic        m_tlast
);
	import dwd_pkg::*;

	push_t push;
	rec_t  head;
	logic  room;
	logic  not_empty;

	dwd_decoder #(
		.MAX_HITS(MAX_HITS)
	) u_decoder (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_word  (s_tdata),
		.in_eoe   (s_tlast),
		.room     (room),
		.push     (push)
	);

	dwd_rec_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tvalid && m_tready),
		.head      (head),
		.not_empty (not_empty),
		.room      (room)
	);

	assign m_tvalid = not_empty;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {head.word_count, head.error_code, head.trailing_edge,
	                   head.value, head.channel, head.module_bit};

endmodule

@@ rtl/dwd_decoder.sv @@
module dwd_decoder #(
	parameter int MAX_HITS = dwd_pkg::MAX_HITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [15:0]    in_word,
	input  logic           in_eoe,
	input  logic           room,
	output dwd_pkg::push_t push
);
	import dwd_pkg::*;

	localparam int HIT_W = $clog2(MAX_HITS + 1);
	localparam logic [HIT_W:0] HIT_LIMIT = MAX_HITS[HIT_W:0];

	localparam logic [1:0] PH_SIZE = 2'd0;
	localparam logic [1:0] PH_ID   = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam logic [1:0] PH_HIGH = 2'd3;

	localparam logic [1:0] SEG_SKIP = 2'd0;
	localparam logic [1:0] SEG_ADC  = 2'd1;
	localparam logic [1:0] SEG_TDC  = 2'd2;

	localparam logic [1:0] LAYER_GLOBAL    = 2'd0;
	localparam logic [1:0] LAYER_IN_GLOBAL = 2'd1;
	localparam logic [1:0] LAYER_TDC       = 2'd2;

	localparam logic [4:0] TDC_GLOBAL_HDR = 5'h08;
	localparam logic [4:0] TDC_GLOBAL_TRL = 5'h10;
	localparam logic [4:0] TDC_EXT_TIME   = 5'h11;
	localparam logic [4:0] TDC_HDR        = 5'h01;
	localparam logic [4:0] TDC_MEAS       = 5'h00;
	localparam logic [4:0] TDC_ERR        = 5'h04;
	localparam logic [4:0] TDC_TRL        = 5'h03;

	localparam logic [1:0] ADC_DATA   = 2'b00;
	localparam logic [1:0] ADC_HEADER = 2'b01;
	localparam logic [1:0] ADC_EOE    = 2'b11;
	localparam logic [10:0] ADC_DATA_ID = 11'h020;

	logic               valid_s1;
	logic [15:0]        word_s1;
	logic               eoe_s1;
	logic               advance;

	logic [1:0]         phase_q, phase_d;
	logic signed [16:0] seg_q, seg_d, sl_dec;
	logic [1:0]         kind_q, kind_d;
	logic [15:0]        low_q, low_d;
	logic [9:0]         adc_left_q, adc_left_d;
	logic               adc_mod_q, adc_mod_d;
	logic [1:0]         layer_q, layer_d;
	logic [HIT_W-1:0]   hit_q, hit_d;
	logic [HIT_W:0]     hit_inc;
	logic               abort_q, abort_d;
	logic [15:0]        words_q, words_inc;
	logic [31:0]        full;
	logic               has_rec;
	rec_t               rec, done;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
			eoe_s1  <= in_eoe;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		seg_d      = seg_q;
		kind_d     = kind_q;
		low_d      = low_q;
		adc_left_d = adc_left_q;
		adc_mod_d  = adc_mod_q;
		layer_d    = layer_q;
		hit_d      = hit_q;
		abort_d    = abort_q;
		has_rec    = 1'b0;
		rec        = '0;
		full       = {word_s1, low_q};
		sl_dec     = seg_q - 17'sd1;
		hit_inc    = {1'b0, hit_q} + {{HIT_W{1'b0}}, 1'b1};
		words_inc  = (words_q != 16'hffff) ? words_q + 16'd1 : words_q;

		if (!abort_q) begin
			case (phase_q)
				PH_SIZE: begin
					seg_d   = $signed({1'b0, word_s1}) - 17'sd2;
					phase_d = PH_ID;
				end
				PH_ID: begin
					kind_d     = (word_s1 == 16'd1) ? SEG_ADC :
					             (word_s1 == 16'd2) ? SEG_TDC : SEG_SKIP;
					layer_d    = LAYER_GLOBAL;
					adc_left_d = '0;
					phase_d    = (seg_q > 17'sd0) ? PH_LOW : PH_SIZE;
				end
				PH_LOW: begin
					low_d   = word_s1;
					seg_d   = sl_dec;
					phase_d = PH_HIGH;
				end
				default: begin
					seg_d = sl_dec;
					case (kind_q)
						SEG_ADC: begin
							if (adc_left_q != 10'd0) begin
								adc_left_d = adc_left_q - 10'd1;
								case (full[31:30])
									ADC_DATA: begin
										has_rec = 1'b1;
										if (full[31:21] == ADC_DATA_ID) begin
											rec.kind       = KIND_ADC_HIT;
											rec.module_bit = adc_mod_q;
											rec.channel    = {2'b00, full[20:16]};
											rec.value      = {3'b000, full[15:0]};
										end else begin
											rec = err_rec(ERR_ADC_NON_EVENT);
										end
									end
									ADC_EOE: begin
									end
									default: begin
										has_rec = 1'b1;
										rec     = err_rec(ERR_ADC_UNKNOWN);
									end
								endcase
							end else if (full[31:30] == ADC_HEADER) begin
								adc_mod_d  = full[16];
								adc_left_d = full[9:0];
							end else begin
								has_rec = 1'b1;
								rec     = err_rec(ERR_ADC_HEADER);
							end
						end
						SEG_TDC: begin
							case (full[31:27])
								TDC_GLOBAL_HDR: begin
									layer_d = LAYER_IN_GLOBAL;
								end
								TDC_GLOBAL_TRL: begin
									if (layer_q != LAYER_IN_GLOBAL) begin
										has_rec = 1'b1;
										rec     = err_rec(ERR_LAYER_ORDER);
									end else begin
										layer_d = LAYER_GLOBAL;
									end
								end
								TDC_EXT_TIME: begin
								end
								TDC_HDR: begin
									if (layer_q != LAYER_IN_GLOBAL) begin
										has_rec = 1'b1;
										rec     = err_rec(ERR_LAYER_ORDER);
									end else begin
										layer_d = LAYER_TDC;
									end
								end
								TDC_MEAS: begin
									has_rec = 1'b1;
									if (layer_q != LAYER_TDC) begin
										abort_d = 1'b1;
										rec     = err_rec(ERR_OUTSIDE_LAYER);
									end else begin
										hit_d = hit_inc[HIT_W-1:0];
										if (hit_inc >= HIT_LIMIT) begin
											abort_d = 1'b1;
											rec     = err_rec(ERR_HIT_LIMIT);
										end else begin
											rec.kind          = KIND_TDC_HIT;
											rec.channel       = full[25:19];
											rec.value         = full[18:0];
											rec.trailing_edge = full[26];
										end
									end
								end
								TDC_ERR: begin
									has_rec = 1'b1;
									rec     = err_rec(ERR_TDC_ERROR);
								end
								TDC_TRL: begin
									if (layer_q != LAYER_TDC) begin
										has_rec = 1'b1;
										rec     = err_rec(ERR_LAYER_ORDER);
									end else begin
										layer_d = LAYER_IN_GLOBAL;
									end
								end
								default: begin
									has_rec = 1'b1;
									rec     = err_rec(ERR_TDC_UNKNOWN);
								end
							endcase
						end
						default: begin
						end
					endcase
					phase_d = (adc_left_d != 10'd0 || sl_dec > 17'sd0) ? PH_LOW : PH_SIZE;
				end
			endcase
		end

		rec.last        = !eoe_s1;
		done            = '0;
		done.kind       = KIND_DONE;
		done.word_count = words_inc;
		done.last       = 1'b1;

		push.rec0 = has_rec ? rec : done;
		push.rec1 = done;
		if (!advance) begin
			push.n = 2'd0;
		end else begin
			push.n = {1'b0, has_rec} + {1'b0, eoe_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIZE;
			seg_q      <= '0;
			kind_q     <= SEG_SKIP;
			adc_left_q <= '0;
			adc_mod_q  <= 1'b0;
			layer_q    <= LAYER_GLOBAL;
			hit_q      <= '0;
			abort_q    <= 1'b0;
			words_q    <= '0;
		end else if (advance) begin
			if (eoe_s1) begin
				phase_q    <= PH_SIZE;
				seg_q      <= '0;
				kind_q     <= SEG_SKIP;
				adc_left_q <= '0;
				adc_mod_q  <= 1'b0;
				layer_q    <= LAYER_GLOBAL;
				hit_q      <= '0;
				abort_q    <= 1'b0;
				words_q    <= '0;
			end else begin
				phase_q    <= phase_d;
				seg_q      <= seg_d;
				kind_q     <= kind_d;
				adc_left_q <= adc_left_d;
				adc_mod_q  <= adc_mod_d;
				layer_q    <= layer_d;
				hit_q      <= hit_d;
				abort_q    <= abort_d;
				words_q    <= words_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			low_q <= low_d;
		end
	end

endmodule

@@ rtl/dwd_rec_fifo.sv @@
module dwd_rec_fifo #(
	parameter int DEPTH = dwd_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dwd_pkg::push_t push,
	input  logic           pop,
	output dwd_pkg::rec_t  head,
	output logic           not_empty,
	output logic           room
);
	import dwd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_next;

	assign wr_next   = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
	assign head      = mem_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign room      = cnt_q <= CNT_W'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.rec0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_next] <= push.rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.n == 2'd2) begin
				wr_q <= (wr_next == PTR_W'(DEPTH - 1)) ? '0 : wr_next + PTR_W'(1);
			end else if (push.n != 2'd0) begin
				wr_q <= wr_next;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

endmodule
